/* src/rcmix_pkg.sv */
// ----------------------------------------------------------------------------
// rcmix_pkg
// Shared types, constants and helpers for the four-motor skid-steer mixer.
// ----------------------------------------------------------------------------
package rcmix_pkg;

    // Channel thresholds in microseconds.
    localparam logic [15:0] CH_CENTER     = 16'd1500;
    localparam logic [15:0] CH_LOW        = 16'd1000;
    localparam logic [15:0] CH_HIGH       = 16'd2000;
    localparam logic [15:0] CH_REVERSE    = 16'd1025;
    localparam logic [15:0] CH_POWER_LOW  = 16'd1250;
    localparam logic [15:0] CH_POWER_HIGH = 16'd1750;

    // Throttle dead band and the reciprocal of nine (2^16 / 9, rounded up).
    localparam logic [9:0]  THR_DEADBAND  = 10'd100;
    localparam logic [12:0] RECIP_NINE    = 13'd7282;

    // Clamped operand levels never exceed this full-scale value.
    localparam logic [9:0]  LEVEL_MAX     = 10'd1000;

    // Power codes and selector schemes.
    localparam logic [5:0]  POWER_MID     = 6'h0C;
    localparam logic [5:0]  POWER_LOW     = 6'h3D;
    localparam logic [5:0]  POWER_HIGH    = 6'h3F;
    localparam logic [1:0]  SCHEME_MID    = 2'd0;
    localparam logic [1:0]  SCHEME_LOW    = 2'd1;
    localparam logic [1:0]  SCHEME_HIGH   = 2'd2;
    localparam logic [1:0]  SCHEME_NONE   = 2'd3;

    // Motor modes.
    localparam logic [1:0]  MODE_STOP     = 2'd0;
    localparam logic [1:0]  MODE_BRAKE    = 2'd1;
    localparam logic [1:0]  MODE_FORWARD  = 2'd2;
    localparam logic [1:0]  MODE_BACKWARD = 2'd3;

    // PWM write commands.
    localparam logic [1:0]  PWM_NONE      = 2'd0;
    localparam logic [1:0]  PWM_ZERO      = 2'd1;
    localparam logic [1:0]  PWM_FULL      = 2'd2;

    // Queue between the front and back parts.
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // Control and status fields of one result.
    typedef struct packed {
        logic       takeover;
        logic       force_run;
        logic       clear_fault;
        logic [5:0] power_code;
        logic       mode_write;
        logic [1:0] motor_mode;
        logic [1:0] pwm_write;
        logic       drive_valid;
    } t_ctl;

    // One classified frame handed from the front to the back.
    typedef struct packed {
        t_ctl       ctl;
        logic [9:0] thr;
        logic [9:0] spd;
        logic [9:0] dir;
        logic [9:0] dst;
    } t_entry;

    // Offset of a channel from 1500, clamped to -500..500 and shifted to 0..1000.
    function automatic logic [9:0] centred(input logic [15:0] ch);
        logic [15:0] diff;
        begin
            diff = ch - CH_LOW;
            if (ch < CH_LOW) begin
                centred = '0;
            end else if (ch > CH_HIGH) begin
                centred = LEVEL_MAX;
            end else begin
                centred = diff[9:0];
            end
        end
    endfunction

endpackage

/* src/rcmix_front.sv */
// ----------------------------------------------------------------------------
// rcmix_front
// Takes one frame, updates the takeover, scheme, running and force-run state,
// and forms the control fields and clamped operands of the frame.
// ----------------------------------------------------------------------------
module rcmix_front (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_accept,
    input  logic [15:0]           i_ch_direction,
    input  logic [15:0]           i_ch_speed,
    input  logic [15:0]           i_ch_throttle,
    input  logic [15:0]           i_ch_distribution,
    input  logic [15:0]           i_ch_takeover,
    input  logic [15:0]           i_ch_power,
    output rcmix_pkg::t_entry     o_entry
);

    logic       r_taken,   n_taken;
    logic [1:0] r_scheme,  n_scheme;
    logic       r_running, n_running;
    logic       r_force,   n_force;
    logic [5:0] r_power,   n_power;

    // Frame classification and state update.
    always_comb begin
        logic        entering;
        logic        running0;
        logic        spd_rev;
        logic [1:0]  scheme;
        logic [1:0]  last;
        logic [9:0]  thrc;
        logic [9:0]  thr_off;
        logic [22:0] ninth_prod;
        logic [6:0]  ninth;
        logic        clear;
        logic        mw;
        logic [1:0]  mode;
        logic [1:0]  pwm;
        logic        go;
        logic [9:0]  thr;

        n_taken   = r_taken;
        n_scheme  = r_scheme;
        n_running = r_running;
        n_force   = r_force;
        n_power   = r_power;
        clear     = 1'b0;
        mw        = 1'b0;
        mode      = rcmix_pkg::MODE_STOP;
        pwm       = rcmix_pkg::PWM_NONE;
        go        = 1'b0;
        thr       = '0;
        entering  = 1'b0;
        running0  = r_running;
        last      = r_scheme;
        scheme    = rcmix_pkg::SCHEME_MID;
        spd_rev   = (i_ch_speed < rcmix_pkg::CH_REVERSE);
        thrc      = rcmix_pkg::centred(i_ch_throttle);
        thr_off   = thrc - rcmix_pkg::THR_DEADBAND;
        ninth_prod = 23'(thr_off) * 23'(rcmix_pkg::RECIP_NINE);
        ninth     = ninth_prod[22:16];

        if (i_ch_takeover < rcmix_pkg::CH_CENTER) begin
            // Release hands control back once.
            if (r_taken) begin
                n_taken   = 1'b0;
                n_running = 1'b0;
                clear     = 1'b1;
                mw        = 1'b1;
                mode      = rcmix_pkg::MODE_STOP;
                pwm       = rcmix_pkg::PWM_ZERO;
            end
        end else begin
            // Entry into takeover.
            entering = !r_taken;
            if (entering) begin
                n_taken  = 1'b1;
                last     = rcmix_pkg::SCHEME_NONE;
                running0 = 1'b0;
                n_force  = (i_ch_direction < rcmix_pkg::CH_REVERSE) && spd_rev;
                clear    = 1'b1;
                mw       = 1'b1;
                mode     = rcmix_pkg::MODE_BRAKE;
                pwm      = rcmix_pkg::PWM_FULL;
            end
            n_running = running0;

            // Power selector; the code changes only with the scheme.
            if (i_ch_power < rcmix_pkg::CH_POWER_LOW) begin
                scheme = rcmix_pkg::SCHEME_LOW;
            end else if (i_ch_power > rcmix_pkg::CH_POWER_HIGH) begin
                scheme = rcmix_pkg::SCHEME_HIGH;
            end
            n_scheme = scheme;
            if (scheme != last) begin
                case (scheme)
                    rcmix_pkg::SCHEME_LOW:  n_power = rcmix_pkg::POWER_LOW;
                    rcmix_pkg::SCHEME_HIGH: n_power = rcmix_pkg::POWER_HIGH;
                    default:                n_power = rcmix_pkg::POWER_MID;
                endcase
            end

            // Throttle: idle, stop, start or run.
            if (thrc < rcmix_pkg::THR_DEADBAND) begin
                if (running0) begin
                    n_running = 1'b0;
                    mw        = 1'b1;
                    mode      = rcmix_pkg::MODE_BRAKE;
                    go        = 1'b1;
                end
            end else begin
                if (!running0) begin
                    n_running = 1'b1;
                    mw        = 1'b1;
                    mode      = spd_rev ? rcmix_pkg::MODE_BACKWARD : rcmix_pkg::MODE_FORWARD;
                end
                go  = 1'b1;
                thr = {ninth, 3'b000} + {2'b00, ninth, 1'b0};
            end
        end

        o_entry.ctl.takeover    = n_taken;
        o_entry.ctl.force_run   = n_force;
        o_entry.ctl.clear_fault = clear;
        o_entry.ctl.power_code  = n_power;
        o_entry.ctl.mode_write  = mw;
        o_entry.ctl.motor_mode  = mw ? mode : rcmix_pkg::MODE_STOP;
        o_entry.ctl.pwm_write   = pwm;
        o_entry.ctl.drive_valid = go;
        o_entry.thr             = thr;
        o_entry.spd             = rcmix_pkg::centred(i_ch_speed);
        o_entry.dir             = rcmix_pkg::centred(i_ch_direction);
        o_entry.dst             = rcmix_pkg::centred(i_ch_distribution);
    end

    // Frame state, updated on every accepted item.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_taken   <= 1'b0;
            r_scheme  <= rcmix_pkg::SCHEME_NONE;
            r_running <= 1'b0;
            r_force   <= 1'b0;
            r_power   <= '0;
        end else if (i_accept) begin
            r_taken   <= n_taken;
            r_scheme  <= n_scheme;
            r_running <= n_running;
            r_force   <= n_force;
            r_power   <= n_power;
        end
    end

endmodule

/* src/rcmix_queue.sv */
// ----------------------------------------------------------------------------
// rcmix_queue
// Short queue of classified frames between the front and the back.
// ----------------------------------------------------------------------------
module rcmix_queue (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  rcmix_pkg::t_entry i_data,
    input  logic              i_pop,
    output logic              o_full,
    output logic              o_empty,
    output rcmix_pkg::t_entry o_data
);

    rcmix_pkg::t_entry                r_mem [rcmix_pkg::QUEUE_DEPTH];
    logic [rcmix_pkg::QPTR_W-1:0]     r_wr_ptr;
    logic [rcmix_pkg::QPTR_W-1:0]     r_rd_ptr;
    logic [rcmix_pkg::QCNT_W-1:0]     r_count;
    logic                             wr_en;
    logic                             rd_en;

    assign o_full  = (r_count == rcmix_pkg::QCNT_W'(rcmix_pkg::QUEUE_DEPTH));
    assign o_empty = (r_count == '0);
    assign wr_en   = i_push && !o_full;
    assign rd_en   = i_pop && !o_empty;
    assign o_data  = r_mem[r_rd_ptr];

    // Storage.
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    // Pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (wr_en) begin
                r_wr_ptr <= (r_wr_ptr == rcmix_pkg::QPTR_W'(rcmix_pkg::QUEUE_DEPTH - 1))
                            ? '0 : r_wr_ptr + 1'b1;
            end
            if (rd_en) begin
                r_rd_ptr <= (r_rd_ptr == rcmix_pkg::QPTR_W'(rcmix_pkg::QUEUE_DEPTH - 1))
                            ? '0 : r_rd_ptr + 1'b1;
            end
            if (wr_en && !rd_en) begin
                r_count <= r_count + 1'b1;
            end else if (rd_en && !wr_en) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

/* src/rcmix_back.sv */
// ----------------------------------------------------------------------------
// rcmix_back
// Mixes throttle, speed, steering and distribution into four drive levels
// with one shared multiplier and a reciprocal divide by 2000, then holds the
// finished item in the output register.
// ----------------------------------------------------------------------------
module rcmix_back (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_q_empty,
    input  rcmix_pkg::t_entry i_q_data,
    output logic              o_q_pop,
    input  logic              i_pop,
    output logic              o_empty,
    output rcmix_pkg::t_ctl   o_ctl,
    output logic [11:0]       o_left_a,
    output logic [11:0]       o_left_b,
    output logic [11:0]       o_right_a,
    output logic [11:0]       o_right_b
);

    // Reciprocal of 2000 scaled by 2^34, rounded up; exact for products below 2^23.
    localparam logic [23:0] RECIP_2000 = 24'd8589935;
    localparam int          RECIP_SH   = 34;
    localparam logic [12:0] DRIVE_GAIN = 13'd8190;

    // Steps of the mixing sequence.
    localparam logic [3:0] STEP_SPEED   = 4'd0;
    localparam logic [3:0] STEP_LEFT    = 4'd1;
    localparam logic [3:0] STEP_RIGHT   = 4'd2;
    localparam logic [3:0] STEP_LA_MIX  = 4'd3;
    localparam logic [3:0] STEP_LA_OUT  = 4'd4;
    localparam logic [3:0] STEP_LB_MIX  = 4'd5;
    localparam logic [3:0] STEP_LB_OUT  = 4'd6;
    localparam logic [3:0] STEP_RA_MIX  = 4'd7;
    localparam logic [3:0] STEP_RA_OUT  = 4'd8;
    localparam logic [3:0] STEP_RB_MIX  = 4'd9;
    localparam logic [3:0] STEP_RB_OUT  = 4'd10;

    // Phases of one step.
    localparam logic [1:0] PH_MUL   = 2'd0;
    localparam logic [1:0] PH_RECIP = 2'd1;
    localparam logic [1:0] PH_STORE = 2'd2;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_FINISH
    } t_state;

    t_state            r_state;
    logic [3:0]        r_step;
    logic [1:0]        r_phase;
    logic              r_out_valid;
    rcmix_pkg::t_ctl   r_ctl;
    rcmix_pkg::t_ctl   r_out_ctl;
    logic [9:0]        r_thr, r_spd, r_dir, r_dst;
    logic [9:0]        r_left, r_right, r_tmp;
    logic [11:0]       r_la, r_lb, r_ra, r_rb;
    logic [11:0]       r_out_la, r_out_lb, r_out_ra, r_out_rb;
    logic [22:0]       r_prod;
    logic [46:0]       r_wide;

    logic [9:0]        op_a;
    logic [12:0]       op_b;
    logic [11:0]       quot;
    logic [9:0]        quot_cap;
    logic              load_out;
    logic              last_step;

    assign o_q_pop   = (r_state == ST_IDLE) && !i_q_empty;
    assign load_out  = (r_state == ST_FINISH) && (!r_out_valid || i_pop);
    assign last_step = (r_step == STEP_RB_OUT);
    assign quot      = r_wide[RECIP_SH+11:RECIP_SH];
    assign quot_cap  = (quot > 12'(rcmix_pkg::LEVEL_MAX)) ? rcmix_pkg::LEVEL_MAX : quot[9:0];

    // Operand selection for the shared multiplier.
    always_comb begin
        op_a = '0;
        op_b = '0;
        case (r_step)
            STEP_SPEED: begin
                op_a = r_thr;
                op_b = 13'd1500 + 13'(r_spd);
            end
            STEP_LEFT: begin
                op_a = r_thr;
                op_b = {1'b0, r_dir, 2'b00};
            end
            STEP_RIGHT: begin
                op_a = r_thr;
                op_b = {1'b0, rcmix_pkg::LEVEL_MAX - r_dir, 2'b00};
            end
            STEP_LA_MIX: begin
                op_a = r_left;
                op_b = 13'd2500 - 13'(r_dst);
            end
            STEP_LB_MIX: begin
                op_a = r_left;
                op_b = 13'd1500 + 13'(r_dst);
            end
            STEP_RA_MIX: begin
                op_a = r_right;
                op_b = 13'd1500 + 13'(r_dst);
            end
            STEP_RB_MIX: begin
                op_a = r_right;
                op_b = 13'd2500 - 13'(r_dst);
            end
            STEP_LA_OUT, STEP_LB_OUT, STEP_RA_OUT, STEP_RB_OUT: begin
                op_a = r_tmp;
                op_b = DRIVE_GAIN;
            end
            default: begin
                op_a = '0;
                op_b = '0;
            end
        endcase
    end

    // Sequencer and output register control.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_step      <= STEP_SPEED;
            r_phase     <= PH_MUL;
            r_out_valid <= 1'b0;
        end else begin
            // The output register fills with a finished item and empties on a pop.
            if (load_out) begin
                r_out_valid <= 1'b1;
            end else if (i_pop && r_out_valid) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                ST_IDLE: begin
                    if (o_q_pop) begin
                        r_step  <= STEP_SPEED;
                        r_phase <= PH_MUL;
                        r_state <= i_q_data.ctl.drive_valid ? ST_RUN : ST_FINISH;
                    end
                end
                ST_RUN: begin
                    case (r_phase)
                        PH_MUL:   r_phase <= PH_RECIP;
                        PH_RECIP: r_phase <= PH_STORE;
                        default: begin
                            r_phase <= PH_MUL;
                            if (last_step) begin
                                r_state <= ST_FINISH;
                            end else begin
                                r_step <= r_step + 1'b1;
                            end
                        end
                    endcase
                end
                ST_FINISH: begin
                    if (load_out) begin
                        r_state <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    // Datapath: multiply, reciprocal multiply, then store to the step's target.
    always_ff @(posedge i_clk) begin
        if (o_q_pop) begin
            r_ctl <= i_q_data.ctl;
            r_thr <= i_q_data.thr;
            r_spd <= i_q_data.spd;
            r_dir <= i_q_data.dir;
            r_dst <= i_q_data.dst;
            r_la  <= '0;
            r_lb  <= '0;
            r_ra  <= '0;
            r_rb  <= '0;
        end
        if (r_state == ST_RUN) begin
            case (r_phase)
                PH_MUL:   r_prod <= 23'(op_a) * 23'(op_b);
                PH_RECIP: r_wide <= 47'(r_prod) * 47'(RECIP_2000);
                default: begin
                    case (r_step)
                        STEP_SPEED:  r_thr   <= quot_cap;
                        STEP_LEFT:   r_left  <= quot_cap;
                        STEP_RIGHT:  r_right <= quot_cap;
                        STEP_LA_OUT: r_la    <= quot;
                        STEP_LB_OUT: r_lb    <= quot;
                        STEP_RA_OUT: r_ra    <= quot;
                        STEP_RB_OUT: r_rb    <= quot;
                        default:     r_tmp   <= quot_cap;
                    endcase
                end
            endcase
        end
        if (load_out) begin
            r_out_ctl <= r_ctl;
            r_out_la  <= r_la;
            r_out_lb  <= r_lb;
            r_out_ra  <= r_ra;
            r_out_rb  <= r_rb;
        end
    end

    assign o_empty   = !r_out_valid;
    assign o_ctl     = r_out_ctl;
    assign o_left_a  = r_out_la;
    assign o_left_b  = r_out_lb;
    assign o_right_a = r_out_ra;
    assign o_right_b = r_out_rb;

endmodule

/* src/rc_four_motor_skid_steer_mixer.sv */
// ----------------------------------------------------------------------------
// rc_four_motor_skid_steer_mixer
// Turns one frame of six RC channels into takeover control and four drive levels.
// ----------------------------------------------------------------------------
// Usage:
// The input side is a queue: drive the six channel pulse widths and raise push
// while full is low; each such edge takes one frame. The result side is a
// queue too: while empty is low the result of the oldest frame is on the o_
// ports, and an edge with pop high takes it. Every frame gives one result.
// The front classifies a frame in its accept cycle and writes it to a
// two-entry queue. The back mixes it with one shared multiplier over eleven
// steps, each a multiply, a reciprocal multiply and a store. It takes
// the next frame from the queue only once the last one has gone to the
// output register, and a frame without drive levels skips the steps.
// While the receiver stalls, the finished result waits in the output
// register and the front keeps taking frames until the queue fills, then
// full holds the sender.
// Reset (i_rst_n low at a clock edge) empties both queues, releases takeover,
// clears the running and force-run flags, the power code and the scheme.
// ----------------------------------------------------------------------------
module rc_four_motor_skid_steer_mixer (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        push,
    output logic        full,
    input  logic [15:0] i_ch_direction,
    input  logic [15:0] i_ch_speed,
    input  logic [15:0] i_ch_throttle,
    input  logic [15:0] i_ch_distribution,
    input  logic [15:0] i_ch_takeover,
    input  logic [15:0] i_ch_power,
    output logic        empty,
    input  logic        pop,
    output logic        o_takeover,
    output logic        o_force_run,
    output logic        o_clear_fault,
    output logic [5:0]  o_power_code,
    output logic        o_mode_write,
    output logic [1:0]  o_motor_mode,
    output logic [1:0]  o_pwm_write,
    output logic        o_drive_valid,
    output logic [11:0] o_drive_left_a,
    output logic [11:0] o_drive_left_b,
    output logic [11:0] o_drive_right_a,
    output logic [11:0] o_drive_right_b
);

    rcmix_pkg::t_entry front_entry;
    rcmix_pkg::t_entry q_data;
    rcmix_pkg::t_ctl   out_ctl;
    logic              accept;
    logic              q_empty;
    logic              q_pop;

    assign accept = push && !full;

    // Front: classify each accepted item and update the takeover state.
    rcmix_front u_front (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_accept          (accept),
        .i_ch_direction    (i_ch_direction),
        .i_ch_speed        (i_ch_speed),
        .i_ch_throttle     (i_ch_throttle),
        .i_ch_distribution (i_ch_distribution),
        .i_ch_takeover     (i_ch_takeover),
        .i_ch_power        (i_ch_power),
        .o_entry           (front_entry)
    );

    // Queue between front and back.
    rcmix_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (accept),
        .i_data  (front_entry),
        .i_pop   (q_pop),
        .o_full  (full),
        .o_empty (q_empty),
        .o_data  (q_data)
    );

    // Back: mix the drive levels and hold the result.
    rcmix_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_empty (q_empty),
        .i_q_data  (q_data),
        .o_q_pop   (q_pop),
        .i_pop     (pop),
        .o_empty   (empty),
        .o_ctl     (out_ctl),
        .o_left_a  (o_drive_left_a),
        .o_left_b  (o_drive_left_b),
        .o_right_a (o_drive_right_a),
        .o_right_b (o_drive_right_b)
    );

    assign o_takeover    = out_ctl.takeover;
    assign o_force_run   = out_ctl.force_run;
    assign o_clear_fault = out_ctl.clear_fault;
    assign o_power_code  = out_ctl.power_code;
    assign o_mode_write  = out_ctl.mode_write;
    assign o_motor_mode  = out_ctl.motor_mode;
    assign o_pwm_write   = out_ctl.pwm_write;
    assign o_drive_valid = out_ctl.drive_valid;

endmodule
